FILE: rtl/hsvs_pkg.sv
// Shared types and constants for the HSV to RGB sextant converter.
package hsvs_pkg;

   localparam int HUE_W = 11;
   localparam int CH_W  = 8;

   // Sextant codes
   localparam logic [2:0] SEXT_0   = 3'd0;
   localparam logic [2:0] SEXT_1   = 3'd1;
   localparam logic [2:0] SEXT_2   = 3'd2;
   localparam logic [2:0] SEXT_3   = 3'd3;
   localparam logic [2:0] SEXT_4   = 3'd4;
   localparam logic [2:0] SEXT_MAX = 3'd5;

   localparam logic [8:0]  K_FULL    = 9'd256;
   localparam logic [7:0]  CH_FULL   = 8'hff;
   localparam logic [15:0] SLOPE_TOP = 16'hff00;

   // After the first stage: sextant, gray flag, value, s*k and 255-s
   typedef struct packed {
      logic [2:0]  sext;
      logic        gray;
      logic [7:0]  v;
      logic [15:0] sk;
      logic [7:0]  inv_s;
   } frac_type;

   // After the second stage: the two raw products
   typedef struct packed {
      logic [2:0]  sext;
      logic        gray;
      logic [7:0]  v;
      logic [23:0] d;
      logic [15:0] w;
   } prod_type;

endpackage

FILE: rtl/hsvs_prod.sv
// First two pipeline stages: sextant decode, s*k, then the value products.
module hsvs_prod (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [10:0]         hue,
   input  logic [7:0]          saturation,
   input  logic [7:0]          brightness,
   output logic                out_valid,
   input  logic                out_ready,
   output hsvs_pkg::prod_type  out_word
);

   logic               a_valid_ff, a_valid_in;
   hsvs_pkg::frac_type a_word_ff, a_word_in;
   logic               b_valid_ff, b_valid_in;
   hsvs_pkg::prod_type b_word_ff, b_word_in;
   logic               a_adv, b_adv;
   logic [2:0]         sext_raw;
   logic [8:0]         k;
   logic [16:0]        sk_full;
   logic [15:0]        slope_diff;
   logic [23:0]        d_prod;
   logic [15:0]        w_prod;

   assign b_adv    = !b_valid_ff || out_ready;
   assign a_adv    = !a_valid_ff || b_adv;
   assign in_ready = a_adv;

   // stage A: clamp sextant, pick rising or falling k, form s*k
   always_comb begin
      sext_raw = hue[10:8];
      a_word_in.sext  = (sext_raw > hsvs_pkg::SEXT_MAX) ? hsvs_pkg::SEXT_MAX : sext_raw;
      k = a_word_in.sext[0] ? {1'b0, hue[7:0]} : hsvs_pkg::K_FULL - {1'b0, hue[7:0]};
      sk_full = {1'b0, saturation} * {8'd0, k};
      a_word_in.sk    = sk_full[15:0];
      a_word_in.gray  = (saturation == 8'd0);
      a_word_in.v     = brightness;
      a_word_in.inv_s = hsvs_pkg::CH_FULL - saturation;
      a_valid_in = a_adv ? in_valid : a_valid_ff;
   end

   // stage B: the two value products
   always_comb begin
      slope_diff = hsvs_pkg::SLOPE_TOP - a_word_ff.sk;
      d_prod     = {16'd0, a_word_ff.v} * {8'd0, slope_diff};
      w_prod     = {8'd0, a_word_ff.v} * {8'd0, a_word_ff.inv_s} + 16'd1;
      b_word_in.sext = a_word_ff.sext;
      b_word_in.gray = a_word_ff.gray;
      b_word_in.v    = a_word_ff.v;
      b_word_in.d    = d_prod;
      b_word_in.w    = w_prod;
      b_valid_in = b_adv ? a_valid_ff : b_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   // hold payload while stalled
   always_ff @(posedge clock) begin
      if (a_adv) begin
         a_word_ff <= a_word_in;
      end
      if (b_adv) begin
         b_word_ff <= b_word_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_word  = b_word_ff;

endmodule

FILE: rtl/hsvs_level.sv
// Final stage: rounding corrections, channel routing and output register.
module hsvs_level (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  hsvs_pkg::prod_type  in_word,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [7:0]          red,
   output logic [7:0]          green,
   output logic [7:0]          blue
);

   logic        c_valid_ff, c_valid_in;
   logic [7:0]  red_ff, red_in;
   logic [7:0]  green_ff, green_in;
   logic [7:0]  blue_ff, blue_in;
   logic        c_adv;
   logic [16:0] w_corr;
   logic [24:0] d_corr;
   logic [7:0]  hi, lo, sl;

   assign c_adv    = !c_valid_ff || out_ready;
   assign in_ready = c_adv;

   always_comb begin
      w_corr = {1'b0, in_word.w} + {9'd0, in_word.w[15:8]};
      d_corr = {1'b0, in_word.d} + {9'd0, in_word.d[23:8]} + {17'd0, in_word.v};
      hi = in_word.v;
      lo = w_corr[15:8];
      sl = d_corr[23:16];
      unique case (in_word.sext)
         hsvs_pkg::SEXT_0: begin
            red_in = hi; green_in = sl; blue_in = lo;
         end
         hsvs_pkg::SEXT_1: begin
            red_in = sl; green_in = hi; blue_in = lo;
         end
         hsvs_pkg::SEXT_2: begin
            red_in = lo; green_in = hi; blue_in = sl;
         end
         hsvs_pkg::SEXT_3: begin
            red_in = lo; green_in = sl; blue_in = hi;
         end
         hsvs_pkg::SEXT_4: begin
            red_in = sl; green_in = lo; blue_in = hi;
         end
         default: begin
            red_in = hi; green_in = lo; blue_in = sl;
         end
      endcase
      // zero saturation: drop the levels, output gray
      if (in_word.gray) begin
         red_in   = hi;
         green_in = hi;
         blue_in  = hi;
      end
      c_valid_in = c_adv ? in_valid : c_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (c_adv) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign red       = red_ff;
   assign green     = green_ff;
   assign blue      = blue_ff;

endmodule

FILE: rtl/hsv_to_rgb_sextant_unit.sv
// Throughput: one pixel per cycle while rsp_ready keeps the output moving.
// An accepted req_ word passes three register stages (s*k, the value
// products, then rounding and routing), each with its own valid bit.
// Reset (synchronous, active high) empties all stages; payload registers
// are not reset.
module hsv_to_rgb_sextant_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [10:0] req_hue,
   input  logic [7:0]  req_saturation,
   input  logic [7:0]  req_brightness,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue
);

   logic               prod_valid;
   logic               prod_ready;
   hsvs_pkg::prod_type prod_word;

   hsvs_prod u_prod (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .hue        (req_hue),
      .saturation (req_saturation),
      .brightness (req_brightness),
      .out_valid  (prod_valid),
      .out_ready  (prod_ready),
      .out_word   (prod_word)
   );

   hsvs_level u_level (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .in_word   (prod_word),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .red       (rsp_red),
      .green     (rsp_green),
      .blue      (rsp_blue)
   );

`ifndef SYNTHESIS
   // input can only back up once the output holds an unread word
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("req_ready low with output stage free");

   a_reset_empty: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp_valid)
      else $error("rsp_valid after reset");

   // a gray pixel that flows through unstalled comes out as its value
   a_gray_pass: assert property (@(posedge clock) disable iff (reset)
      ($past(req_valid && req_ready && (req_saturation == 8'd0), 3)
       && $past(rsp_ready, 1) && $past(rsp_ready, 2)
       && !$past(reset, 1) && !$past(reset, 2))
      |-> (rsp_valid && (rsp_red == $past(req_brightness, 3))
           && (rsp_green == $past(req_brightness, 3))
           && (rsp_blue == $past(req_brightness, 3))))
      else $error("gray pixel mismatch");
`endif

endmodule

FILE: tb/hsv_to_rgb_sextant_unit_test.sv
// Self-checking testbench for the HSV to RGB sextant converter.
module hsv_to_rgb_sextant_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_PIXELS = 1950;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int DIRECTED_ROWS = 22;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   typedef struct packed {
      logic [10:0] hue;
      logic [7:0]  sat;
      logic [7:0]  bri;
      logic        typed;
      rgb_type     want;
   } pixel_row_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_RANDOM,
      READY_SPARSE,
      READY_PERIODIC
   } stall_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [10:0] req_hue = '0;
   logic [7:0]  req_saturation = '0;
   logic [7:0]  req_brightness = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;

   // Typed-in expectation travels alongside the payload of a directed word
   logic        row_typed = 1'b0;
   rgb_type     row_expect = '0;

   rgb_type        expected_pixels[$];
   rgb_type        oldest_pixel;
   int             errors = 0;
   int             pixels_in = 0;
   int             pixels_out = 0;
   int             gray_pixels = 0;
   int             clamped_pixels = 0;
   int unsigned    cycle_count = 0;
   int unsigned    stall_left = 0;
   stall_mode_type stall_mode = READY_ALWAYS;

   // Gray, black and the three primaries are typed in; the rest go through the predictor
   pixel_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      '{11'h000, 8'h00, 8'h00, 1'b1, '{8'h00, 8'h00, 8'h00}},
      '{11'h5ff, 8'h00, 8'hff, 1'b1, '{8'hff, 8'hff, 8'hff}},
      '{11'h7ff, 8'h00, 8'h5a, 1'b1, '{8'h5a, 8'h5a, 8'h5a}},
      '{11'h2a5, 8'hff, 8'h00, 1'b1, '{8'h00, 8'h00, 8'h00}},
      '{11'h000, 8'hff, 8'hff, 1'b1, '{8'hff, 8'h00, 8'h00}},
      '{11'h200, 8'hff, 8'hff, 1'b1, '{8'h00, 8'hff, 8'h00}},
      '{11'h400, 8'hff, 8'hff, 1'b1, '{8'h00, 8'h00, 8'hff}},
      '{11'h0ff, 8'hff, 8'hff, 1'b0, '0},
      '{11'h100, 8'hff, 8'hff, 1'b0, '0},
      '{11'h180, 8'h80, 8'hc8, 1'b0, '0},
      '{11'h2ff, 8'h01, 8'hff, 1'b0, '0},
      '{11'h340, 8'hc0, 8'h40, 1'b0, '0},
      '{11'h4a0, 8'h33, 8'hee, 1'b0, '0},
      '{11'h5ff, 8'hff, 8'hff, 1'b0, '0},
      '{11'h500, 8'h7f, 8'h01, 1'b0, '0},
      '{11'h600, 8'hff, 8'hff, 1'b0, '0},
      '{11'h6ab, 8'h55, 8'haa, 1'b0, '0},
      '{11'h7ff, 8'hff, 8'h80, 1'b0, '0},
      '{11'h700, 8'h01, 8'h01, 1'b0, '0},
      '{11'h3ff, 8'hfe, 8'hfe, 1'b0, '0},
      '{11'h0aa, 8'h01, 8'h01, 1'b0, '0},
      '{11'h555, 8'haa, 8'h55, 1'b0, '0}
   };

   hsv_to_rgb_sextant_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic rgb_type convert_pixel(logic [10:0] hue, logic [7:0] sat,
                                             logic [7:0] bri);
      logic [2:0]  sext;
      logic [31:0] k;
      logic [31:0] w;
      logic [31:0] d;
      logic [7:0]  lo;
      logic [7:0]  sl;
      rgb_type     px;
      if (sat == 8'd0) begin
         px = '{bri, bri, bri};
         return px;
      end
      sext = hue[10:8];
      if (sext > hsvs_pkg::SEXT_MAX)
         sext = hsvs_pkg::SEXT_MAX;
      // Rising slope in even sextants, falling in odd ones
      k = sext[0] ? 32'(hue[7:0]) : 32'(hsvs_pkg::K_FULL) - 32'(hue[7:0]);
      w = 32'(bri) * (32'(hsvs_pkg::CH_FULL) - 32'(sat)) + 32'd1;
      w = w + (w >> 8);
      lo = w[15:8];
      d = 32'(bri) * (32'(hsvs_pkg::SLOPE_TOP) - ((32'(sat) * k) & 32'h0000ffff));
      d = d + (d >> 8);
      d = d + 32'(bri);
      sl = d[23:16];
      case (sext)
         hsvs_pkg::SEXT_0: px = '{bri, sl, lo};
         hsvs_pkg::SEXT_1: px = '{sl, bri, lo};
         hsvs_pkg::SEXT_2: px = '{lo, bri, sl};
         hsvs_pkg::SEXT_3: px = '{lo, sl, bri};
         hsvs_pkg::SEXT_4: px = '{sl, lo, bri};
         default:          px = '{bri, lo, sl};
      endcase
      return px;
   endfunction

   task automatic check_channel(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(16, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_RANDOM: rsp_ready <= 1'($urandom_range(0, 1));
         READY_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:      rsp_ready <= (cycle_count % 5) > 1;
      endcase
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_pixels.push_back(row_typed ? row_expect
                                      : convert_pixel(req_hue, req_saturation, req_brightness));
            pixels_in++;
            if (req_saturation == 8'd0)
               gray_pixels++;
            else if (req_hue[10:8] > hsvs_pkg::SEXT_MAX)
               clamped_pixels++;
         end
         if (rsp_valid && rsp_ready) begin
            pixels_out++;
            if (expected_pixels.size() == 0) begin
               $display("%0t ns: unexpected word, expected none, actual %02h %02h %02h",
                        $time, rsp_red, rsp_green, rsp_blue);
               errors++;
            end else begin
               oldest_pixel = expected_pixels.pop_front();
               check_channel("red", oldest_pixel.red, rsp_red);
               check_channel("green", oldest_pixel.green, rsp_green);
               check_channel("blue", oldest_pixel.blue, rsp_blue);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d words outstanding",
                  cycle_count, expected_pixels.size());
         $display("Verification failed");
         $finish;
      end
   end

   // Hold the word until the edge at which it is taken
   task automatic send_pixel(logic [10:0] hue, logic [7:0] sat, logic [7:0] bri,
                             logic typed, rgb_type want);
      req_valid      <= 1'b1;
      req_hue        <= hue;
      req_saturation <= sat;
      req_brightness <= bri;
      row_typed      <= typed;
      row_expect     <= want;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do
         @(negedge clock);
      while (expected_pixels.size() != 0);
      @(posedge clock);
   endtask

   initial begin
      int          n;
      int          gap;
      int          burst_left;
      logic [10:0] hue;
      logic [7:0]  sat;
      logic [7:0]  bri;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < DIRECTED_ROWS; n++)
         send_pixel(directed_rows[n].hue, directed_rows[n].sat, directed_rows[n].bri,
                    directed_rows[n].typed, directed_rows[n].want);
      wait_drained();

      burst_left = 0;
      for (n = 0; n < RANDOM_PIXELS; n++) begin
         if (n == RANDOM_PIXELS / 2)
            wait_drained();
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = $urandom_range(1, 40);
         end
         burst_left--;
         case ($urandom_range(0, 15))
            0:       hue = 11'($urandom_range(1536, 2047));
            1:       hue = 11'($urandom_range(0, 5) * 256 + ($urandom_range(0, 1) ? 255 : 0));
            default: hue = 11'($urandom_range(0, 1535));
         endcase
         case ($urandom_range(0, 9))
            0:       sat = 8'h00;
            1:       sat = 8'hff;
            2:       sat = 8'h01;
            default: sat = 8'($urandom_range(0, 255));
         endcase
         case ($urandom_range(0, 9))
            0:       bri = 8'h00;
            1:       bri = 8'hff;
            default: bri = 8'($urandom_range(0, 255));
         endcase
         send_pixel(hue, sat, bri, 1'b0, '0);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_pixels.size() != 0)
         errors++;

      $display("Converted %0d pixels, %0d gray and %0d with sextant code 6 or 7,",
               pixels_in, gray_pixels, clamped_pixels);
      $display("under bursty input and stalled output; %0d words checked, %0d errors",
               pixels_out, errors);
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
